@@ rtl/lrj_pkg.sv @@
// ----------------------------------------------------------------------------
// lrj_pkg: shared types and constants
// Transfer payloads, margin thresholds and kind codes for the line run
// justification classifier.
// ----------------------------------------------------------------------------
package lrj_pkg;

  // Input line transfer
  typedef struct packed {
    logic       line_blank;
    logic       line_claimed;
    logic [7:0] line_indent;
    logic [7:0] line_length;
    logic       final_line;
  } lrj_in_t;

  // Result transfer, one per finished run
  typedef struct packed {
    logic [15:0] run_start;
    logic [15:0] run_lines;
    logic [1:0]  run_kind;
  } lrj_out_t;

  // Thresholds derived from the right margin
  typedef struct packed {
    logic [7:0] margin;   // rm
    logic [7:0] center;   // rm / 2
    logic [7:0] right;    // rm * 8 / 10
    logic [7:0] tol;      // rm / 8
    logic [7:0] quarter;  // rm / 4
  } lrj_thr_t;

  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_RIGHT  = 2'd1;
  localparam logic [1:0] KIND_CENTER = 2'd2;

  localparam logic [7:0]  RM_RESET     = 8'd72;
  localparam logic        REG_RMARGIN  = 1'b0;   // register index 0
  localparam int          CFG_ADDR_W   = 3;
  localparam logic [15:0] CNT_SAT      = 16'hFFFF;

endpackage

@@ rtl/lrj_cfg.sv @@
// ----------------------------------------------------------------------------
// lrj_cfg: configuration register
// Holds right_margin behind the APB-style port and derives the thresholds.
// ----------------------------------------------------------------------------
module lrj_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrj_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output lrj_pkg::lrj_thr_t             thr
);

  logic [7:0]  margin_r;
  logic [7:0]  margin_nxt;
  logic        wr_en;
  logic [17:0] right_prod;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite &&
                  (paddr[lrj_pkg::CFG_ADDR_W-1] == lrj_pkg::REG_RMARGIN);

  always_comb begin
    margin_nxt = margin_r;
    if (wr_en) begin
      margin_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= lrj_pkg::RM_RESET;
    end else begin
      margin_r <= margin_nxt;
    end
  end

  assign prdata = (paddr[lrj_pkg::CFG_ADDR_W-1] == lrj_pkg::REG_RMARGIN) ?
                  {24'd0, margin_r} : 32'd0;

  // rm*8/10 = (4*rm)/5; 4*rm stays below 1024, so *205 >> 10 is exact
  assign right_prod = {8'd0, margin_r, 2'b00} * 18'd205;

  assign thr.margin  = margin_r;
  assign thr.center  = {1'b0, margin_r[7:1]};
  assign thr.right   = right_prod[17:10];
  assign thr.tol     = {3'b000, margin_r[7:3]};
  assign thr.quarter = {2'b00, margin_r[7:2]};

endmodule

@@ rtl/lrj_run.sv @@
// ----------------------------------------------------------------------------
// lrj_run: run tracker
// Keeps the per-run state, absorbs one line per transfer and forms the
// result of a run as it closes.
// ----------------------------------------------------------------------------
module lrj_run #(
  parameter int MAX_LINES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  lrj_pkg::lrj_in_t  item,
  input  lrj_pkg::lrj_thr_t thr,
  output logic              res_valid,
  output lrj_pkg::lrj_out_t res
);

  localparam logic [15:0] INDEX_LIMIT =
    (MAX_LINES - 1 > 65535) ? 16'hFFFF : 16'(MAX_LINES - 1);

  logic [15:0] line_index_r, line_index_nxt;
  logic        in_run_r, in_run_nxt;
  logic [15:0] start_index_r, start_index_nxt;
  logic [15:0] run_count_r, run_count_nxt;
  logic [7:0]  first_indent_r, first_indent_nxt;
  logic [15:0] same_count_r, same_count_nxt;
  logic        right_ok_r, right_ok_nxt;
  logic        center_ok_r, center_ok_nxt;
  logic        before_blank_r, before_blank_nxt;
  logic        last_blank_r, last_blank_nxt;

  logic        text_line, opens, absorbs, breaks, in_run_after;
  logic [15:0] cnt_base, same_base;
  logic        right_base, center_base;
  logic [8:0]  span;
  logic [9:0]  span_hi, rm_hi;
  logic        same_hit, right_fail, center_fail;
  logic        after_blank;
  logic [17:0] same_x3, count_x2;
  logic [1:0]  kind;

  assign text_line    = !item.line_blank && !item.line_claimed;
  assign opens        = !in_run_r && text_line;
  assign absorbs      = opens || (in_run_r && text_line);
  assign breaks       = in_run_r && !text_line;
  assign in_run_after = absorbs;

  // Per-line tests against the run's first indent and the margin
  assign first_indent_nxt = opens ? item.line_indent : first_indent_r;
  assign span     = {1'b0, item.line_indent} + {1'b0, item.line_length};
  assign span_hi  = {1'b0, span} + {2'b00, thr.tol};
  assign rm_hi    = {2'b00, thr.margin} + {2'b00, thr.tol};
  assign same_hit = (item.line_indent <= first_indent_nxt) &&
                    (({1'b0, item.line_indent} + 9'd2) >= {1'b0, first_indent_nxt});
  assign right_fail  = (item.line_indent < thr.center) ||
                       (item.line_length < thr.right);
  assign center_fail = (item.line_indent == 8'd0) ||
                       (span_hi < {2'b00, thr.margin}) ||
                       ({1'b0, span} > rm_hi);

  // Restart the counters on the opening line
  assign cnt_base    = opens ? 16'd0 : run_count_r;
  assign same_base   = opens ? 16'd0 : same_count_r;
  assign right_base  = opens ? 1'b1 : right_ok_r;
  assign center_base = opens ? 1'b1 : center_ok_r;

  always_comb begin
    run_count_nxt = cnt_base;
    same_count_nxt = same_base;
    right_ok_nxt = right_base;
    center_ok_nxt = center_base;
    if (absorbs) begin
      if (cnt_base != lrj_pkg::CNT_SAT) begin
        run_count_nxt = cnt_base + 16'd1;
      end
      if (same_hit && (same_base != lrj_pkg::CNT_SAT)) begin
        same_count_nxt = same_base + 16'd1;
      end
      if (right_fail) begin
        right_ok_nxt = 1'b0;
      end
      if (center_fail) begin
        center_ok_nxt = 1'b0;
      end
    end
  end

  assign start_index_nxt  = opens ? line_index_r : start_index_r;
  assign before_blank_nxt = opens ? last_blank_r : before_blank_r;

  // A breaking line leaves the state untouched, so the updated values serve
  // both the break and the final-line close
  assign after_blank = breaks ? item.line_blank : 1'b1;
  assign same_x3     = {2'b00, same_count_nxt} + {1'b0, same_count_nxt, 1'b0};
  assign count_x2    = {1'b0, run_count_nxt, 1'b0};

  always_comb begin
    kind = lrj_pkg::KIND_PLAIN;
    if (before_blank_nxt && after_blank) begin
      if (center_ok_nxt && (first_indent_nxt > thr.quarter) &&
          ((run_count_nxt == 16'd1) || (same_x3 < count_x2))) begin
        kind = lrj_pkg::KIND_CENTER;
      end else if (right_ok_nxt) begin
        kind = lrj_pkg::KIND_RIGHT;
      end
    end
  end

  assign res_valid     = breaks || (item.final_line && in_run_after);
  assign res.run_start = start_index_nxt;
  assign res.run_lines = run_count_nxt;
  assign res.run_kind  = kind;

  assign in_run_nxt     = in_run_after && !item.final_line;
  assign last_blank_nxt = item.final_line ? 1'b1 : item.line_blank;

  always_comb begin
    line_index_nxt = line_index_r;
    if (item.final_line) begin
      line_index_nxt = 16'd0;
    end else if (line_index_r < INDEX_LIMIT) begin
      line_index_nxt = line_index_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_index_r   <= 16'd0;
      in_run_r       <= 1'b0;
      start_index_r  <= 16'd0;
      run_count_r    <= 16'd0;
      first_indent_r <= 8'd0;
      same_count_r   <= 16'd0;
      right_ok_r     <= 1'b1;
      center_ok_r    <= 1'b1;
      before_blank_r <= 1'b1;
      last_blank_r   <= 1'b1;
    end else if (take) begin
      line_index_r   <= line_index_nxt;
      in_run_r       <= in_run_nxt;
      start_index_r  <= start_index_nxt;
      run_count_r    <= run_count_nxt;
      first_indent_r <= first_indent_nxt;
      same_count_r   <= same_count_nxt;
      right_ok_r     <= right_ok_nxt;
      center_ok_r    <= center_ok_nxt;
      before_blank_r <= before_blank_nxt;
      last_blank_r   <= last_blank_nxt;
    end
  end

endmodule

@@ rtl/line_run_justify_classifier_top.sv @@
// ----------------------------------------------------------------------------
// line_run_justify_classifier_top: line run justification classifier
// Groups runs of unclaimed text lines and classifies each finished run as
// plain, right justified or centered.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one text line per transfer (in_data). Lines are
//   numbered from 0 within a document; final_line closes the document and
//   the next line starts again at index 0.
//   out_valid/out_ready carry one result per finished run (out_data): start
//   index, saturating line count and kind. Lines that close no run produce
//   no transfer.
//   Pipeline: a line is captured in the input register; the run tracker
//   evaluates it combinationally from that register, and when the line
//   advances its result is loaded into the output register, which drives
//   out_valid and out_data.
//   Throughput: one line per cycle while no held result stalls a closing
//   line, as the run tracker updates its state with each accepted line.
//   Stalls: a held result in the output register blocks only a line that
//   itself closes a run; other lines keep flowing through the tracker.
//   Reset (rst_n low, synchronous): pipeline empties, run state returns to
//   "outside a run, previous line blank", right_margin returns to 72.
//   Configuration: write right_margin at byte address 0 over the APB-style
//   port while the block is idle.
// ----------------------------------------------------------------------------
module line_run_justify_classifier_top #(
  parameter int MAX_LINES = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // line input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lrj_pkg::lrj_in_t               in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output lrj_pkg::lrj_out_t              out_data,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrj_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  lrj_pkg::lrj_thr_t thr;
  lrj_pkg::lrj_in_t  stage_r;
  logic              stage_vld_r, stage_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  lrj_pkg::lrj_out_t out_r;
  lrj_pkg::lrj_out_t res;
  logic              res_valid;
  logic              advance;
  logic              in_xfer;
  logic              load_out;

  lrj_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // Advance the staged line unless it closes a run and the output is held
  assign advance  = stage_vld_r && (!res_valid || !out_vld_r || out_ready);
  assign in_ready = !stage_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;
  assign load_out = advance && res_valid;

  lrj_run #(
    .MAX_LINES (MAX_LINES)
  ) u_run (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (advance),
    .item      (stage_r),
    .thr       (thr),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (in_xfer) begin
      stage_vld_nxt = 1'b1;
    end else if (advance) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_r <= in_data;
    end
    if (load_out) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ rtl/lrj_chk.sv @@
// ----------------------------------------------------------------------------
// lrj_chk: port checker
// Watches the top level's ports for result channel and reset behavior.
// ----------------------------------------------------------------------------
module lrj_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input lrj_pkg::lrj_out_t out_data,
  input logic              pready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.run_kind == lrj_pkg::KIND_PLAIN) ||
                  (out_data.run_kind == lrj_pkg::KIND_RIGHT) ||
                  (out_data.run_kind == lrj_pkg::KIND_CENTER))
    else $error("illegal run kind");

  a_lines_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.run_lines != 16'd0)
    else $error("run of zero lines");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("result present after reset");

endmodule

bind line_run_justify_classifier_top lrj_chk u_lrj_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: line run justification classifier
// Streams text lines through the classifier and predicts every finished run
// (start index, saturating line count, kind) with an in-bench model of the
// run tracker. Results are compared field by field in order. Covers directed
// corner cases and randomized documents under several right margin
// settings, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LINE_CAP = 65536;
  // highest line index the tracker can hold
  localparam int LINE_TOP = (LINE_CAP - 1 > 65535) ? 65535 : LINE_CAP - 1;
  localparam int PHASE_LINES = 190;
  localparam int CFG_AW = lrj_pkg::CFG_ADDR_W;

  typedef enum int {STYLE_PLAIN, STYLE_RIGHT, STYLE_CENTER, STYLE_NOISE} line_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  lrj_pkg::lrj_in_t      in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  lrj_pkg::lrj_out_t     out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_AW-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  line_run_justify_classifier_top #(.MAX_LINES(LINE_CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // Lines waiting to be driven, and finished runs we expect to see, in order
  lrj_pkg::lrj_in_t  line_q[$];
  lrj_pkg::lrj_out_t run_expect_q[$];
  int       lines_queued = 0;
  int       lines_taken = 0;
  int       errors = 0;

  // --------------------------------------------------------------------------
  // Run tracker prediction. State mirrors the block's reset values.
  // --------------------------------------------------------------------------
  logic [7:0]  margin = lrj_pkg::RM_RESET;
  logic [15:0] cur_line = '0;
  bit          open_run = 1'b0;
  logic [15:0] run_first_line = '0;
  logic [15:0] run_len = '0;
  logic [7:0]  first_col = '0;
  logic [15:0] aligned_len = '0;
  bit          fits_right = 1'b1;
  bit          fits_center = 1'b1;
  bit          lead_blank = 1'b1;
  bit          prev_blank = 1'b1;

  // Fold one line into the open run: counters and per-line margin tests.
  function automatic void absorb_into_run(logic [7:0] ind, logic [7:0] len);
    int rm;
    int tol;
    int slack;
    rm = margin;
    tol = rm / 8;
    slack = int'(ind) + int'(len) - rm;
    if (run_len != lrj_pkg::CNT_SAT) run_len++;
    // indent within two columns below the first indent
    if (ind <= first_col && int'(ind) + 2 >= int'(first_col)) begin
      if (aligned_len != lrj_pkg::CNT_SAT) aligned_len++;
    end
    if (int'(ind) < rm / 2 || int'(len) < rm * 8 / 10) fits_right = 1'b0;
    if (ind == 0 || slack < -tol || slack > tol) fits_center = 1'b0;
  endfunction

  // Close the open run and queue its classification.
  function automatic void close_run(bit tail_blank);
    lrj_pkg::lrj_out_t r;
    int       n;
    int       s;
    n = run_len;
    s = aligned_len;
    r.run_start = run_first_line;
    r.run_lines = run_len;
    r.run_kind  = lrj_pkg::KIND_PLAIN;
    // only runs framed by blank lines on both sides get a non-plain kind
    if (lead_blank && tail_blank) begin
      if (fits_center && int'(first_col) > int'(margin) / 4 && (n == 1 || s * 3 < n * 2)) begin
        r.run_kind = lrj_pkg::KIND_CENTER;
      end else if (fits_right) begin
        r.run_kind = lrj_pkg::KIND_RIGHT;
      end
    end
    run_expect_q.push_back(r);
    open_run = 1'b0;
  endfunction

  function automatic void track_line(lrj_pkg::lrj_in_t ln);
    if (open_run) begin
      // a claimed line ends the run; its own blank flag frames the tail
      if (ln.line_blank || ln.line_claimed) begin
        close_run(ln.line_blank);
      end else begin
        absorb_into_run(ln.line_indent, ln.line_length);
      end
    end else if (!ln.line_blank && !ln.line_claimed) begin
      open_run       = 1'b1;
      run_first_line = cur_line;
      run_len        = '0;
      first_col      = ln.line_indent;
      aligned_len    = '0;
      fits_right     = 1'b1;
      fits_center    = 1'b1;
      lead_blank     = prev_blank;
      absorb_into_run(ln.line_indent, ln.line_length);
    end
    // document edge counts as blank
    if (ln.final_line && open_run) close_run(1'b1);
    prev_blank = ln.line_blank;
    if (cur_line < LINE_TOP) cur_line++;
    if (ln.final_line) begin
      cur_line  = '0;
      open_run  = 1'b0;
      prev_blank = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Line driver: bursts of random length, random gaps between bursts.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        // predict at the transfer, then count it
        track_line(in_data);
        lines_taken++;
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      // hold valid and payload until the transfer happens
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_q.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          in_data  <= line_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: stall pattern switches between always ready, random
  // stalls and a fixed one-in-three duty.
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase == 2) ? 0 : stall_phase + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_phase == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare every transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  lrj_pkg::lrj_out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (run_expect_q.size() == 0) begin
        $display("%0t: unexpected run result, expected none, got start %0d lines %0d kind %0d",
                 $time, out_data.run_start, out_data.run_lines, out_data.run_kind);
        errors++;
      end else begin
        want = run_expect_q.pop_front();
        if (out_data.run_start !== want.run_start) begin
          $display("%0t: run_start expected %0d got %0d", $time, want.run_start,
                   out_data.run_start);
          errors++;
        end
        if (out_data.run_lines !== want.run_lines) begin
          $display("%0t: run_lines expected %0d got %0d", $time, want.run_lines,
                   out_data.run_lines);
          errors++;
        end
        if (out_data.run_kind !== want.run_kind) begin
          $display("%0t: run_kind expected %0d got %0d", $time, want.run_kind,
                   out_data.run_kind);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic lrj_pkg::lrj_in_t mk_line(bit blank, bit claimed, int ind, int len,
                                               bit fin);
    lrj_pkg::lrj_in_t ln;
    ln.line_blank   = blank;
    ln.line_claimed = claimed;
    ln.line_indent  = ind[7:0];
    ln.line_length  = len[7:0];
    ln.final_line   = fin;
    return ln;
  endfunction

  function automatic logic [7:0] col8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Build one text line shaped for the current margin.
  function automatic lrj_pkg::lrj_in_t text_line(line_style_t style);
    lrj_pkg::lrj_in_t ln;
    int      rm;
    int      ind;
    int      len;
    rm = margin;
    ln = '0;
    case (style)
      STYLE_CENTER: begin
        // line end near the margin, indent at or above a quarter of it
        ind = $urandom_range(rm / 4, rm);
        len = rm - ind + $urandom_range(0, 2 * (rm / 8) + 2) - (rm / 8) - 1;
      end
      STYLE_RIGHT: begin
        ind = $urandom_range(rm / 2, rm / 2 + 24) - ($urandom_range(0, 7) == 0);
        len = $urandom_range(rm * 8 / 10, rm * 8 / 10 + 30) - ($urandom_range(0, 7) == 0);
      end
      STYLE_NOISE: begin
        ind = $urandom_range(0, 255);
        len = $urandom_range(0, 255);
        ln.line_blank   = ($urandom_range(0, 3) == 0);
        ln.line_claimed = ($urandom_range(0, 3) == 0);
        ln.final_line   = ($urandom_range(0, 19) == 0);
      end
      default: begin
        ind = $urandom_range(0, 12);
        len = $urandom_range(0, 255);
      end
    endcase
    ln.line_indent = col8(ind);
    ln.line_length = col8(len);
    return ln;
  endfunction

  task automatic queue_line(lrj_pkg::lrj_in_t ln);
    line_q.push_back(ln);
    lines_queued++;
  endtask

  // One paragraph of a document, then whatever closes it.
  task automatic queue_paragraph();
    line_style_t style;
    int          lines;
    int          closer;
    lrj_pkg::lrj_in_t ln;
    style  = line_style_t'($urandom_range(0, 2));
    lines  = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    closer = $urandom_range(0, 9);
    for (int k = 0; k < lines; k++) begin
      if ($urandom_range(0, 4) == 0) ln = text_line(line_style_t'($urandom_range(0, 2)));
      else ln = text_line(style);
      // end the document on the run's own last line
      if (closer == 2 && k == lines - 1) ln.final_line = 1'b1;
      queue_line(ln);
    end
    case (closer)
      0: queue_line(mk_line(0, 1, $urandom_range(0, 255), $urandom_range(0, 255), 0));
      1: queue_line(mk_line(1, 1, 0, 0, 0));
      2: ;
      3: queue_line(mk_line(1, 0, 0, 0, 1));
      default: begin
        repeat ($urandom_range(1, 2)) queue_line(mk_line(1, 0, 0, 0, 0));
      end
    endcase
  endtask

  // Wait until every line has been transferred and every run has come back,
  // then let the pipeline empty of lines that close no run.
  task automatic drain();
    while (lines_taken != lines_queued || run_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write right_margin over the configuration port, then read it back.
  task automatic set_margin(logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(lrj_pkg::REG_RMARGIN));
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    margin = value;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata[7:0] !== value) begin
      $display("%0t: right_margin readback expected %0d got %0d", $time, value, prdata[7:0]);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [7:0] margin_plan [8];
  int         phase_base;

  initial begin
    margin_plan[0] = 8'd8;
    margin_plan[1] = 8'd255;
    margin_plan[2] = 8'd0;
    margin_plan[3] = 8'd5;
    margin_plan[4] = 8'd100;
    margin_plan[5] = 8'($urandom_range(8, 255));
    margin_plan[6] = 8'($urandom_range(8, 255));
    margin_plan[7] = 8'd72;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines at the reset margin of 72 (center 36, right 57, tol 9).
    queue_line(mk_line(0, 0, 30, 40, 0));   // single centered line
    queue_line(mk_line(1, 0, 0, 0, 0));
    queue_line(mk_line(0, 0, 40, 60, 0));   // single right justified line
    queue_line(mk_line(1, 0, 0, 0, 0));
    queue_line(mk_line(0, 0, 0, 0, 0));     // all-zero and all-one columns
    queue_line(mk_line(0, 0, 255, 255, 0));
    queue_line(mk_line(1, 0, 0, 0, 0));
    queue_line(mk_line(0, 1, 10, 10, 0));   // claimed line right before a run
    queue_line(mk_line(0, 0, 40, 60, 0));
    queue_line(mk_line(1, 0, 0, 0, 0));
    queue_line(mk_line(0, 0, 40, 60, 0));   // run cut by a non-blank claimed line
    queue_line(mk_line(0, 1, 5, 5, 0));
    queue_line(mk_line(1, 1, 0, 0, 0));     // blank claimed lines frame a run
    queue_line(mk_line(0, 0, 40, 60, 0));
    queue_line(mk_line(1, 1, 0, 0, 0));
    queue_line(mk_line(0, 0, 30, 40, 0));   // centered block, varying indent
    queue_line(mk_line(0, 0, 20, 52, 0));
    queue_line(mk_line(0, 0, 24, 48, 0));
    queue_line(mk_line(1, 0, 0, 0, 0));
    queue_line(mk_line(0, 0, 40, 60, 1));   // run closed by the document end
    queue_line(mk_line(0, 0, 30, 40, 0));
    queue_line(mk_line(1, 0, 0, 0, 1));     // blank final closes the run once
    queue_line(mk_line(1, 0, 255, 255, 1)); // empty document
    queue_line(mk_line(0, 0, 30, 40, 1));   // one-line document

    // Random documents under each margin setting.
    foreach (margin_plan[p]) begin
      drain();
      set_margin(margin_plan[p]);
      phase_base = lines_queued;
      while (lines_queued - phase_base < PHASE_LINES) begin
        if ($urandom_range(0, 9) == 0) queue_line(text_line(STYLE_NOISE));
        else queue_paragraph();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
